// ===== design/ncrq_pkg.sv =====
// Shared types and constants for the neighbor cell radius query block.
package ncrq_pkg;

  localparam int FRAC_BITS = 8;
  localparam int CFG_W     = 16;
  localparam int CS_W      = CFG_W + FRAC_BITS;   // cell size in fixed point
  localparam int GAP_W     = CS_W + 1;            // axis gap, at most 2*cs
  localparam int SQ_W      = 2 * GAP_W;           // squared gap or radius
  localparam int SUM_W     = SQ_W + 1;
  localparam int GRID_W    = 16;
  localparam int POS_W     = 40;
  localparam int RAD_W     = 32;
  localparam int BOUND_W   = POS_W + 1;
  localparam int CELL_W    = 17;
  localparam int NB_COUNT  = 24;
  localparam int NB_IDX_W  = 5;

  // column / row codes of the 5x5 block (offset +2)
  localparam logic [2:0] COL_L2 = 3'd0;
  localparam logic [2:0] COL_L1 = 3'd1;
  localparam logic [2:0] COL_C  = 3'd2;
  localparam logic [2:0] COL_R1 = 3'd3;
  localparam logic [2:0] COL_R2 = 3'd4;

  // raster order of the 24 neighbors, center skipped
  localparam logic [2:0] NB_COL [NB_COUNT] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };
  localparam logic [2:0] NB_ROW [NB_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // Classified query handed from front to back.
  // sqx/sqy hold squared gaps for columns/rows L2, L1, R1, R2; center gap is zero.
  typedef struct packed {
    logic                      ext;
    logic                      named;
    logic                      qual;
    logic signed [GRID_W-1:0]  gx;
    logic signed [GRID_W-1:0]  gy;
    logic [3:0][SQ_W-1:0]      sqx;
    logic [3:0][SQ_W-1:0]      sqy;
    logic [SQ_W-1:0]           r2;
  } ncrq_entry_t;

endpackage

// ===== design/ncrq_front.sv =====
// Front end: accepts queries, checks the own cell and precomputes squared gaps.
module ncrq_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ncrq_pkg::CFG_W-1:0]        cell_size,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_ext,
  input  logic                              in_named,
  input  logic                              in_finite,
  input  logic signed [ncrq_pkg::GRID_W-1:0] in_gx,
  input  logic signed [ncrq_pkg::GRID_W-1:0] in_gy,
  input  logic signed [ncrq_pkg::POS_W-1:0]  in_px,
  input  logic signed [ncrq_pkg::POS_W-1:0]  in_py,
  input  logic [ncrq_pkg::RAD_W-1:0]        in_radius,
  output logic                              out_valid,
  output ncrq_pkg::ncrq_entry_t             out_entry,
  input  logic                              out_ready
);
  import ncrq_pkg::*;

  logic [CS_W-1:0]  cs;
  logic [GAP_W-1:0] two_cs;

  // stage A: cell origin
  logic                       a_valid;
  logic                       a_ext, a_named, a_fin;
  logic signed [GRID_W-1:0]   a_gx, a_gy;
  logic signed [POS_W-1:0]    a_px, a_py;
  logic [RAD_W-1:0]           a_rad;
  logic signed [BOUND_W-1:0]  a_minx, a_miny;

  // stage B: own cell check, offsets, clamped radius
  logic                       b_valid;
  logic                       b_ext, b_named, b_qual;
  logic signed [GRID_W-1:0]   b_gx, b_gy;
  logic [CS_W-1:0]            b_ox, b_oy;
  logic [GAP_W-1:0]           b_rb;

  // stage C: squares
  logic                       c_valid;
  ncrq_entry_t                c_entry;

  logic                       ready_a, ready_b, ready_c;
  logic signed [BOUND_W-1:0]  px_w, py_w, hi_x, hi_y, off_x, off_y;
  logic                       in_cell;
  logic [GAP_W-1:0]           rb_next;
  logic [GAP_W-1:0]           gx0, gx1, gx3, gx4, gy0, gy1, gy3, gy4;
  ncrq_entry_t                c_entry_next;

  assign cs     = {cell_size, {FRAC_BITS{1'b0}}};
  assign two_cs = {cs, 1'b0};

  assign ready_c  = !c_valid || out_ready;
  assign ready_b  = !b_valid || ready_c;
  assign ready_a  = !a_valid || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ready_a) begin
      a_valid <= in_valid;
    end
    if (ready_a) begin
      a_ext   <= in_ext;
      a_named <= in_named;
      a_fin   <= in_finite;
      a_gx    <= in_gx;
      a_gy    <= in_gy;
      a_px    <= in_px;
      a_py    <= in_py;
      a_rad   <= in_radius;
      a_minx  <= $signed(in_gx) * $signed({1'b0, cs});
      a_miny  <= $signed(in_gy) * $signed({1'b0, cs});
    end
  end

  always_comb begin
    px_w    = BOUND_W'(a_px);
    py_w    = BOUND_W'(a_py);
    hi_x    = a_minx + BOUND_W'(cs);
    hi_y    = a_miny + BOUND_W'(cs);
    off_x   = px_w - a_minx;
    off_y   = py_w - a_miny;
    in_cell = (px_w >= a_minx) && (px_w <= hi_x) && (py_w >= a_miny) && (py_w <= hi_y);
    if (a_rad > RAD_W'(two_cs)) begin
      rb_next = two_cs;
    end else begin
      rb_next = a_rad[GAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid;
    end
    if (ready_b) begin
      b_ext   <= a_ext;
      b_named <= a_named;
      b_qual  <= a_ext && a_fin && (a_rad != '0) && in_cell;
      b_gx    <= a_gx;
      b_gy    <= a_gy;
      b_ox    <= off_x[CS_W-1:0];
      b_oy    <= off_y[CS_W-1:0];
      b_rb    <= rb_next;
    end
  end

  // offsets lie in [0, cs] once the position is inside its own cell
  always_comb begin
    gx0 = GAP_W'(b_ox) + GAP_W'(cs);
    gx1 = GAP_W'(b_ox);
    gx3 = GAP_W'(cs) - GAP_W'(b_ox);
    gx4 = two_cs - GAP_W'(b_ox);
    gy0 = GAP_W'(b_oy) + GAP_W'(cs);
    gy1 = GAP_W'(b_oy);
    gy3 = GAP_W'(cs) - GAP_W'(b_oy);
    gy4 = two_cs - GAP_W'(b_oy);
    c_entry_next.ext    = b_ext;
    c_entry_next.named  = b_named;
    c_entry_next.qual   = b_qual;
    c_entry_next.gx     = b_gx;
    c_entry_next.gy     = b_gy;
    c_entry_next.sqx[0] = gx0 * gx0;
    c_entry_next.sqx[1] = gx1 * gx1;
    c_entry_next.sqx[2] = gx3 * gx3;
    c_entry_next.sqx[3] = gx4 * gx4;
    c_entry_next.sqy[0] = gy0 * gy0;
    c_entry_next.sqy[1] = gy1 * gy1;
    c_entry_next.sqy[2] = gy3 * gy3;
    c_entry_next.sqy[3] = gy4 * gy4;
    c_entry_next.r2     = b_rb * b_rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (ready_c) begin
      c_valid <= b_valid;
    end
    if (ready_c) begin
      c_entry <= c_entry_next;
    end
  end

  assign out_valid = c_valid;
  assign out_entry = c_entry;

endmodule

// ===== design/ncrq_fifo.sv =====
// Short queue of classified queries between front and back.
module ncrq_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  ncrq_pkg::ncrq_entry_t          push_data,
  output logic                           full,
  output logic                           head_valid,
  output ncrq_pkg::ncrq_entry_t          head,
  input  logic                           pop,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import ncrq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  ncrq_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/ncrq_back.sv =====
// Back end: walks the 24 neighbors of the queue head and emits hit cells.
module ncrq_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  ncrq_pkg::ncrq_entry_t              head,
  output logic                               pop,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic signed [ncrq_pkg::CELL_W-1:0] out_cell_x,
  output logic signed [ncrq_pkg::CELL_W-1:0] out_cell_y,
  output logic                               out_last
);
  import ncrq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [NB_IDX_W-1:0] IDX_LAST = NB_IDX_W'(NB_COUNT - 1);

  logic [1:0]                state, state_next;
  logic [NB_IDX_W-1:0]       idx, idx_next;
  logic signed [CELL_W-1:0]  pend_x, pend_y, pend_x_next, pend_y_next;

  logic [2:0]                col, row;
  logic [SQ_W-1:0]           sq_col, sq_row;
  logic [SUM_W-1:0]          dist2;
  logic                      hit, slot;
  logic signed [CELL_W-1:0]  own_x, own_y, nb_x, nb_y;
  logic                      emit, emit_kind, emit_last;
  logic signed [CELL_W-1:0]  emit_x, emit_y;

  assign col = NB_COL[idx];
  assign row = NB_ROW[idx];

  always_comb begin
    case (col)
      COL_L2:  sq_col = head.sqx[0];
      COL_L1:  sq_col = head.sqx[1];
      COL_R1:  sq_col = head.sqx[2];
      COL_R2:  sq_col = head.sqx[3];
      default: sq_col = '0;
    endcase
    case (row)
      COL_L2:  sq_row = head.sqy[0];
      COL_L1:  sq_row = head.sqy[1];
      COL_R1:  sq_row = head.sqy[2];
      COL_R2:  sq_row = head.sqy[3];
      default: sq_row = '0;
    endcase
  end

  assign dist2 = SUM_W'(sq_col) + SUM_W'(sq_row);
  assign hit   = (dist2 <= SUM_W'(head.r2));
  assign own_x = CELL_W'(head.gx);
  assign own_y = CELL_W'(head.gy);
  assign nb_x  = own_x + CELL_W'($signed({1'b0, col})) - CELL_W'(2);
  assign nb_y  = own_y + CELL_W'($signed({1'b0, row})) - CELL_W'(2);
  assign slot  = !out_valid || out_ready;
  assign busy  = (state != ST_IDLE);

  // pend holds the latest cell; it goes out once the next hit or the end shows its tlast
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pend_x_next = pend_x;
    pend_y_next = pend_y;
    pop         = 1'b0;
    emit        = 1'b0;
    emit_kind   = 1'b1;
    emit_x      = pend_x;
    emit_y      = pend_y;
    emit_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (!head.ext) begin
            if (!head.named) begin
              pop = 1'b1;
            end else if (slot) begin
              emit      = 1'b1;
              emit_kind = 1'b0;
              emit_x    = '0;
              emit_y    = '0;
              emit_last = 1'b1;
              pop       = 1'b1;
            end
          end else if (!head.qual) begin
            if (slot) begin
              emit      = 1'b1;
              emit_x    = own_x;
              emit_y    = own_y;
              emit_last = 1'b1;
              pop       = 1'b1;
            end
          end else if (hit) begin
            if (slot) begin
              emit        = 1'b1;
              emit_x      = own_x;
              emit_y      = own_y;
              pend_x_next = nb_x;
              pend_y_next = nb_y;
              idx_next    = idx + 1'b1;
              state_next  = ST_SCAN;
            end
          end else begin
            pend_x_next = own_x;
            pend_y_next = own_y;
            idx_next    = idx + 1'b1;
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!hit || slot) begin
          if (hit) begin
            emit        = 1'b1;
            pend_x_next = nb_x;
            pend_y_next = nb_y;
          end
          if (idx == IDX_LAST) begin
            idx_next   = '0;
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (slot) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          pop        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        idx_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    pend_x <= pend_x_next;
    pend_y <= pend_y_next;
    if (emit) begin
      out_kind   <= emit_kind;
      out_cell_x <= emit_x;
      out_cell_y <= emit_y;
      out_last   <= emit_last;
    end
  end

endmodule

// ===== design/neighbor_cell_radius_query.sv =====
// Neighbor cell radius query: from a query word to a stream of grid cells in reach.
// A query passes front stages A, B, C, the queue and the back end output register.
// The back end takes one query at a time. Queries that do not scan need no neighbor tests;
// a scanning exterior query gets one neighbor test per cycle unless a hit must wait.
// The front end takes a query word every cycle until the queue between the two fills.
// Reset (rst, synchronous): pipeline, queue and output emptied; cell_size returns to 8192.
module neighbor_cell_radius_query #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,       // cell_size
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // grid_x, grid_y, pos_x, pos_y, radius
  input  logic [2:0]   s_axis_tuser,   // is_exterior, has_interior_name, values_finite
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // cell_x, cell_y, zero pad
  output logic [0:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast
);
  import ncrq_pkg::*;

  localparam logic [CFG_W-1:0] CELL_SIZE_RESET = CFG_W'(8192);

  logic [CFG_W-1:0]           cell_size;
  logic                       fr_valid, q_full, q_head_valid, q_pop, back_busy;
  ncrq_entry_t                fr_entry, q_head;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  logic signed [CELL_W-1:0]   out_cell_x, out_cell_y;
  logic                       out_kind;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cell_size <= cfg_data;
    end
  end

  ncrq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cell_size (cell_size),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_ext    (s_axis_tuser[0]),
    .in_named  (s_axis_tuser[1]),
    .in_finite (s_axis_tuser[2]),
    .in_gx     (s_axis_tdata[15:0]),
    .in_gy     (s_axis_tdata[31:16]),
    .in_px     (s_axis_tdata[71:32]),
    .in_py     (s_axis_tdata[111:72]),
    .in_radius (s_axis_tdata[143:112]),
    .out_valid (fr_valid),
    .out_entry (fr_entry),
    .out_ready (!q_full)
  );

  ncrq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_data  (fr_entry),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .count      (q_count)
  );

  ncrq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .busy       (back_busy),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_cell_x (out_cell_x),
    .out_cell_y (out_cell_y),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_cell_y, out_cell_x};
  assign m_axis_tuser = out_kind;

`ifndef ASSERT_OFF
  // an interior word is always a lone word at the origin
  a_interior_lone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata[33:0] == '0)))
    else $error("interior word without tlast or with nonzero cell");

  // queue occupancy bounded by its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // back end only scans while the query it works on is still held in the queue
  a_scan_has_head: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> q_head_valid)
    else $error("back end busy with empty queue");

  // a scan starts only for a qualified exterior query
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    $rose(back_busy) |-> (q_head.ext && q_head.qual))
    else $error("scan started on a query that does not scan");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for neighbor_cell_radius_query: queries in, cells in reach checked out.
module tb;
  import ncrq_pkg::*;

  typedef struct {
    logic                     ext;
    logic                     named;
    logic                     finite;
    logic signed [GRID_W-1:0] gx;
    logic signed [GRID_W-1:0] gy;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic [RAD_W-1:0]         radius;
  } query_t;

  typedef struct {
    logic                     kind;
    logic signed [CELL_W-1:0] cx;
    logic signed [CELL_W-1:0] cy;
    logic                     last;
  } cell_t;

  localparam logic KIND_INTERIOR = 1'b0;
  localparam logic KIND_EXTERIOR = 1'b1;
  localparam int   REACH         = 2;

  // Works out the cells a query reaches and checks them as they come out.
  class reach_checker;
    cell_t           cells_due[$];
    logic [CFG_W-1:0] cell_size = 16'd8192;
    int              errors = 0;

    function void push_cell(logic kind, longint x, longint y);
      cell_t c;
      c.kind = kind;
      c.cx   = x[CELL_W-1:0];
      c.cy   = y[CELL_W-1:0];
      c.last = 1'b0;
      cells_due = {cells_due, c};
    endfunction

    function longint gap_to_span(longint p, longint lo, longint hi);
      if (p < lo) return lo - p;
      if (p > hi) return p - hi;
      return 0;
    endfunction

    function void note_query(query_t q);
      longint csf, gx, gy, px, py, minx, miny, rb, r2, cx, cy, lx, ly, ex, ey;
      cell_t  tail;
      csf = longint'(cell_size) << FRAC_BITS;
      gx  = longint'(q.gx);
      gy  = longint'(q.gy);
      px  = longint'(q.px);
      py  = longint'(q.py);
      if (!q.ext) begin
        if (q.named) begin
          push_cell(KIND_INTERIOR, 0, 0);
          tail = cells_due.pop_back();
          tail.last = 1'b1;
          cells_due = {cells_due, tail};
        end
        return;
      end
      push_cell(KIND_EXTERIOR, gx, gy);
      minx = gx * csf;
      miny = gy * csf;
      if (q.finite && q.radius != 0 &&
          !(px < minx || px > minx + csf || py < miny || py > miny + csf)) begin
        rb = longint'(q.radius);
        if (rb > 2 * csf) rb = 2 * csf;
        r2 = rb * rb;
        for (int dy = -REACH; dy <= REACH; dy++) begin
          for (int dx = -REACH; dx <= REACH; dx++) begin
            if (dx == 0 && dy == 0) continue;
            cx = gx + dx;
            cy = gy + dy;
            lx = cx * csf;
            ly = cy * csf;
            ex = gap_to_span(px, lx, lx + csf);
            ey = gap_to_span(py, ly, ly + csf);
            if (ex * ex + ey * ey <= r2) push_cell(KIND_EXTERIOR, cx, cy);
          end
        end
      end
      tail = cells_due.pop_back();
      tail.last = 1'b1;
      cells_due = {cells_due, tail};
    endfunction

    function void check_cell(logic kind, logic signed [CELL_W-1:0] cx,
                             logic signed [CELL_W-1:0] cy, logic last);
      cell_t e;
      if (cells_due.size() == 0) begin
        $error("unexpected cell word: kind %0d x %0d y %0d last %0d", kind, cx, cy, last);
        errors++;
        return;
      end
      e = cells_due.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (cx !== e.cx) begin
        $error("cell_x: expected %0d, got %0d", e.cx, cx);
        errors++;
      end
      if (cy !== e.cy) begin
        $error("cell_y: expected %0d, got %0d", e.cy, cy);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int idle_pct  = 0;
  int stall_pct = 0;
  reach_checker sb;

  neighbor_cell_radius_query dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_cell(m_axis_tuser[0], m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tlast);
  end

  function automatic query_t mk(logic ext, logic named, logic finite, longint gx,
                                longint gy, longint px, longint py, longint radius);
    query_t q;
    q.ext    = ext;
    q.named  = named;
    q.finite = finite;
    q.gx     = gx[GRID_W-1:0];
    q.gy     = gy[GRID_W-1:0];
    q.px     = px[POS_W-1:0];
    q.py     = py[POS_W-1:0];
    q.radius = radius[RAD_W-1:0];
    return q;
  endfunction

  function automatic longint pick_offset(longint csf);
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1) return csf;
    return longint'($urandom_range(32'(csf), 0));
  endfunction

  // exterior query placed inside its own cell, random radius around the clamp
  function automatic query_t in_cell_query();
    longint csf, gx, gy;
    int     k;
    query_t q;
    csf = longint'(sb.cell_size) << FRAC_BITS;
    gx  = longint'($signed(16'($urandom)));
    gy  = longint'($signed(16'($urandom)));
    q   = mk(1'b1, 1'($urandom), ($urandom_range(19) != 0), gx, gy,
             gx * csf + pick_offset(csf), gy * csf + pick_offset(csf), 0);
    k = $urandom_range(9);
    if (k == 1) q.radius = $urandom;
    else if (k > 1) q.radius = $urandom_range(32'(3 * csf + 256), 1);
    return q;
  endfunction

  function automatic query_t noise_query();
    query_t q;
    q.ext    = 1'($urandom);
    q.named  = 1'($urandom);
    q.finite = 1'($urandom);
    q.gx     = 16'($urandom);
    q.gy     = 16'($urandom);
    q.px     = {8'($urandom), 32'($urandom)};
    q.py     = {8'($urandom), 32'($urandom)};
    q.radius = $urandom;
    return q;
  endfunction

  task automatic send_query(query_t q);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q.radius, q.py, q.px, q.gy, q.gx};
    s_axis_tuser  <= {q.finite, q.named, q.ext};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_query(q);
  endtask

  // drain every cell due, then give queries with no output time to leave the pipe
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.cells_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cell_size(logic [15:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.cell_size = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int count);
    int     sent, k;
    query_t q;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(99);
      if (k < 70) q = in_cell_query();
      else if (k < 80) begin
        q = noise_query();
        q.ext = 1'b0;
      end else q = noise_query();
      send_query(q);
      if (q.ext || q.named) sent++;
    end
  endtask

  initial begin
    longint csf;
    sb = new();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset cell size, no idling: special cases and extremes
    csf = 64'd8192 << FRAC_BITS;
    send_query(mk(1'b0, 1'b0, 1'b1, 5, 5, 0, 0, 100));
    send_query(mk(1'b0, 1'b1, 1'b0, -1, -1, -1, -1, 32'hFFFF_FFFF));
    send_query(mk(1'b1, 1'b1, 1'b0, 0, 0, csf / 2, csf / 2, 32'hFFFF_FFFF));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, csf / 2, csf / 2, 0));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, csf + 1, 0, 32'hFFFF_FFFF));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, csf / 2, csf / 2, 32'hFFFF_FFFF));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, 0, 0, 256));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, csf, csf, csf));
    send_query(mk(1'b1, 1'b0, 1'b1, 32767, -32768, 32767 * csf + 1, -32768 * csf + csf,
                  32'hFFFF_FFFF));
    send_query(mk(1'b1, 1'b1, 1'b1, -32768, 32767, -32768 * csf, 32767 * csf + csf / 2,
                  3 * csf / 2));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1, 1));
    send_query(mk(1'b1, 1'b0, 1'b1, -1, -1, -1, -csf, 1000000));
    send_random(20);

    write_cell_size(16'hFFFF);
    idle_pct = 77;
    send_random(20);

    write_cell_size(16'd1);
    idle_pct  = 0;
    stall_pct = 77;
    send_random(20);

    // zero cell size: every cell span collapses onto the origin point
    write_cell_size(16'd0);
    idle_pct  = 7;
    stall_pct = 7;
    send_query(mk(1'b1, 1'b0, 1'b1, 3, -7, 0, 0, 1));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, 1, 0, 500));
    send_query(mk(1'b1, 1'b0, 1'b1, 0, 0, 0, 0, 0));
    send_random(8);

    write_cell_size(16'($urandom_range(65535, 1)));
    send_random(25);

    settle();
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== neighbor_cell_radius_query.f =====
design/ncrq_pkg.sv
design/ncrq_front.sv
design/ncrq_fifo.sv
design/ncrq_back.sv
design/neighbor_cell_radius_query.sv
tb/tb.sv
